FILE: hdl/code39_width_pattern_decode_defines.svh
// assertion helpers for the code 39 decoder
`ifndef CODE39_WIDTH_PATTERN_DECODE_DEFINES_SVH
`define CODE39_WIDTH_PATTERN_DECODE_DEFINES_SVH

// checked on every edge outside reset
`define C39_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("c39wpd assertion failed");

// checked on every edge, reset included
`define C39_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("c39wpd assertion failed");

`endif

FILE: hdl/c39wpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package c39wpd_pkg;

  localparam int NUM_ELEMS   = 9;
  localparam int NUM_SYMBOLS = 44;
  localparam int SYM_IDX_W   = 6;
  localparam int ASCII_W     = 7;
  localparam logic [SYM_IDX_W-1:0] GUARD_INDEX = 6'd39;

  typedef enum logic [1:0] {
    ST_DECODED  = 2'd0,
    ST_NO_WIDE  = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_t;

  typedef logic [NUM_ELEMS-1:0] pattern_t;

  localparam pattern_t SYM_PATTERNS [NUM_SYMBOLS] = '{
    9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
    9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
    9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
    9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0, 9'h085, 9'h184, 9'h0C4, 9'h094,
    9'h0A8, 9'h0A2, 9'h08A, 9'h02A
  };

  // "0-9", "A-Z", then - . space * $ / + %
  localparam logic [ASCII_W-1:0] SYM_ASCII [NUM_SYMBOLS] = '{
    7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57,
    7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd72, 7'd73, 7'd74,
    7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82, 7'd83, 7'd84,
    7'd85, 7'd86, 7'd87, 7'd88, 7'd89, 7'd90,
    7'd45, 7'd46, 7'd32, 7'd42, 7'd36, 7'd47, 7'd43, 7'd37
  };

endpackage
`default_nettype wire

FILE: hdl/c39wpd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface c39wpd_in_if #(
  parameter int WIDTH_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [WIDTH_BITS-1:0] bar_width_0;
  logic [WIDTH_BITS-1:0] bar_width_1;
  logic [WIDTH_BITS-1:0] bar_width_2;
  logic [WIDTH_BITS-1:0] bar_width_3;
  logic [WIDTH_BITS-1:0] bar_width_4;
  logic [WIDTH_BITS-1:0] bar_width_5;
  logic [WIDTH_BITS-1:0] bar_width_6;
  logic [WIDTH_BITS-1:0] bar_width_7;
  logic [WIDTH_BITS-1:0] bar_width_8;

  modport source (
    output valid, bar_width_0, bar_width_1, bar_width_2, bar_width_3, bar_width_4,
           bar_width_5, bar_width_6, bar_width_7, bar_width_8,
    input  ready
  );
  modport sink (
    input  valid, bar_width_0, bar_width_1, bar_width_2, bar_width_3, bar_width_4,
           bar_width_5, bar_width_6, bar_width_7, bar_width_8,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/c39wpd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface c39wpd_out_if
  import c39wpd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  status_t               status;
  pattern_t              wide_pattern;
  logic [SYM_IDX_W-1:0]  symbol_index;
  logic [ASCII_W-1:0]    ascii_code;
  logic                  is_guard;

  modport source (
    output valid, status, wide_pattern, symbol_index, ascii_code, is_guard,
    input  ready
  );
  modport sink (
    input  valid, status, wide_pattern, symbol_index, ascii_code, is_guard,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/code39_width_pattern_decode.sv
// Code 39 character decoder.
// din carries one word per character: the nine measured element widths,
// bar first, in scan order. dout carries one word per character: status,
// the 9-bit wide/narrow pattern, the table index, the ASCII code and a
// flag for the start/stop asterisk. Both channels move a word on a clock
// edge where valid and ready are both high.
// The decoder is a five-stage pipeline: capture, pairwise compares,
// rank counts and wide pattern, wide sum, then the evenness check and
// table match into the output register. An accepted word moves through
// these stages in order to dout. Throughput is one word per cycle unless
// dout stalls; each stage holds its own valid bit.
// When dout stalls, stages hold their words and empty stages keep filling;
// din.ready falls only once every stage is full, so nothing is lost or
// repeated.
// Synchronous reset clears the valid bits only; the pipeline is empty and
// ready on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "code39_width_pattern_decode_defines.svh"
module code39_width_pattern_decode
  import c39wpd_pkg::*;
#(
  parameter int WIDTH_BITS = 12
) (
  input  wire logic     clk,
  input  wire logic     rst,
  c39wpd_in_if.sink     din,
  c39wpd_out_if.source  dout
);

  localparam int CNT_W = $clog2(NUM_ELEMS + 1);
  localparam int SUM_W = WIDTH_BITS + $clog2(NUM_ELEMS);

  typedef logic [WIDTH_BITS-1:0] width_t;

  // stage valids and enables
  logic v1, v2, v3, v4, v5;
  logic e1, e2, e3, e4, e5;

  assign e5 = !v5 || dout.ready;
  assign e4 = !v4 || e5;
  assign e3 = !v3 || e4;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;
  assign din.ready = e1;

  width_t   w1 [NUM_ELEMS];
  width_t   w2 [NUM_ELEMS];
  width_t   w3 [NUM_ELEMS];
  width_t   w4 [NUM_ELEMS];
  pattern_t gt2 [NUM_ELEMS];
  pattern_t nz2;
  pattern_t pat3, pat4;
  logic     found3, found4;
  logic [SUM_W-1:0] total4;

  // stage 2 logic: bit i of gt_next[j] is w[i] > w[j]
  pattern_t gt_next [NUM_ELEMS];
  pattern_t nz_next;
  always_comb begin
    for (int j = 0; j < NUM_ELEMS; j++) begin
      nz_next[j] = (w1[j] != '0);
      for (int i = 0; i < NUM_ELEMS; i++) begin
        gt_next[j][i] = (w1[i] > w1[j]);
      end
    end
  end

  // stage 3 logic: rank counts
  logic [CNT_W-1:0] cnt [NUM_ELEMS];
  pattern_t pat_next;
  logic     found_next;
  always_comb begin
    found_next = 1'b0;
    for (int j = 0; j < NUM_ELEMS; j++) begin
      cnt[j] = CNT_W'($countones(gt2[j]));
      pat_next[NUM_ELEMS-1-j] = (cnt[j] < CNT_W'(3));
      if (nz2[j] && cnt[j] == CNT_W'(3)) begin
        found_next = 1'b1;
      end
    end
  end

  // stage 4 logic: sum of wide widths
  logic [SUM_W-1:0] total_next;
  always_comb begin
    total_next = '0;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      if (pat3[NUM_ELEMS-1-i]) begin
        total_next = total_next + SUM_W'(w3[i]);
      end
    end
  end

  // stage 5 logic: evenness check and table match
  logic                 uneven;
  logic                 hit;
  logic [SYM_IDX_W-1:0] idx;
  always_comb begin
    uneven = 1'b0;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      if (pat4[NUM_ELEMS-1-i] && ((SUM_W'(w4[i]) << 1) >= total4)) begin
        uneven = 1'b1;
      end
    end
    hit = 1'b0;
    idx = '0;
    for (int k = NUM_SYMBOLS - 1; k >= 0; k--) begin
      if (pat4 == SYM_PATTERNS[k]) begin
        hit = 1'b1;
        idx = SYM_IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (e1) v1 <= din.valid;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
      if (e4) v4 <= v3;
      if (e5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      w1[0] <= din.bar_width_0;
      w1[1] <= din.bar_width_1;
      w1[2] <= din.bar_width_2;
      w1[3] <= din.bar_width_3;
      w1[4] <= din.bar_width_4;
      w1[5] <= din.bar_width_5;
      w1[6] <= din.bar_width_6;
      w1[7] <= din.bar_width_7;
      w1[8] <= din.bar_width_8;
    end
    if (e2) begin
      w2  <= w1;
      gt2 <= gt_next;
      nz2 <= nz_next;
    end
    if (e3) begin
      w3     <= w2;
      pat3   <= pat_next;
      found3 <= found_next;
    end
    if (e4) begin
      w4     <= w3;
      pat4   <= pat3;
      found4 <= found3;
      total4 <= total_next;
    end
    if (e5) begin
      if (!found4 || uneven) begin
        dout.status       <= ST_NO_WIDE;
        dout.wide_pattern <= '0;
        dout.symbol_index <= '0;
        dout.ascii_code   <= '0;
        dout.is_guard     <= 1'b0;
      end else if (!hit) begin
        dout.status       <= ST_NO_MATCH;
        dout.wide_pattern <= pat4;
        dout.symbol_index <= '0;
        dout.ascii_code   <= '0;
        dout.is_guard     <= 1'b0;
      end else begin
        dout.status       <= ST_DECODED;
        dout.wide_pattern <= pat4;
        dout.symbol_index <= idx;
        dout.ascii_code   <= SYM_ASCII[idx];
        dout.is_guard     <= (idx == GUARD_INDEX);
      end
    end
  end

  assign dout.valid = v5;

  `C39_ASSERT(a_fail_fields_zero, clk, rst,
    (dout.valid && dout.status != ST_DECODED) |->
      (dout.symbol_index == '0 && dout.ascii_code == '0 && !dout.is_guard))
  `C39_ASSERT(a_no_wide_pattern_zero, clk, rst,
    (dout.valid && dout.status == ST_NO_WIDE) |-> (dout.wide_pattern == '0))
  `C39_ASSERT(a_three_wide, clk, rst,
    (dout.valid && dout.status != ST_NO_WIDE) |-> ($countones(dout.wide_pattern) == 3))
  `C39_ASSERT(a_found_three_ranks, clk, rst,
    (v3 && found3) |-> ($countones(pat3) == 3))
  `C39_ASSERT_ALWAYS(a_ready_when_not_full, clk,
    (!rst && !(v1 && v2 && v3 && v4 && v5)) |-> din.ready)

endmodule
`default_nettype wire
